@@ hdl/rdwta_pkg.sv @@
// ----------------------------------------------------------------------------
// rdwta_pkg - shared types and constants
// Widths of the register file, the result fields and the command / status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package rdwta_pkg;

	localparam int COST_W     = 16;
	localparam int MIN_DISP_W = 9;
	localparam int DISP_OUT_W = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBPIX_EN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVALID_COST = 2'd2;

	typedef struct packed {
		logic busy;      // finishing unit holds a pixel
		logic prep1;     // form denominator and difference
		logic prep2;     // form dividend and divisor
		logic step;      // one restoring division step
		logic load_out;  // write the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic fin_start; // last candidate of a pixel transferred
		logic use_div;   // parabola offset needs the divider
	} dp_stat_t;

endpackage

@@ hdl/rdwta_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdwta_ctrl - pixel finishing sequencer
// Walks one finished pixel through operand setup, the division steps (when an
// offset is computed) and the result register, and owns the output valid.
// ----------------------------------------------------------------------------
module rdwta_ctrl import rdwta_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_stat_t  stat,
	input  logic      out_stall,
	output ctrl_cmd_t cmd,
	output logic      out_valid
);

	localparam int STEPS = FRAC_BITS + 2;
	localparam int SCW   = $clog2(STEPS);
	localparam logic [SCW-1:0] LAST_STEP = SCW'(STEPS - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP1 = 6'b000010,
		S_PREP2 = 6'b000100,
		S_DIV   = 6'b001000,
		S_FIX   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t         state_q, state_nxt;
	logic [SCW-1:0] step_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (stat.fin_start) state_nxt = S_PREP1;
			S_PREP1: state_nxt = S_PREP2;
			S_PREP2: state_nxt = stat.use_div ? S_DIV : S_FIX;
			S_DIV:   if (step_q == LAST_STEP) state_nxt = S_FIX;
			S_FIX:   state_nxt = S_OUT;
			S_OUT:   if (!out_stall) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_PREP2)
				step_q <= '0;
			else if (state_q == S_DIV)
				step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		cmd.busy     = (state_q != S_IDLE);
		cmd.prep1    = (state_q == S_PREP1);
		cmd.prep2    = (state_q == S_PREP2);
		cmd.step     = (state_q == S_DIV);
		cmd.load_out = (state_q == S_FIX);
	end

	assign out_valid = (state_q == S_OUT);

endmodule

@@ hdl/rdwta_dp.sv @@
// ----------------------------------------------------------------------------
// rdwta_dp - winner search and subpixel datapath
// Register file, per-candidate minimum tracking, snapshot of a finished
// pixel, restoring divider for the parabola offset and the result register.
// ----------------------------------------------------------------------------
module rdwta_dp import rdwta_pkg::*; #(
	parameter int MAX_CANDIDATES = 256,
	parameter int FRAC_BITS      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// candidate stream
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COST_W-1:0]     cost,
	input  logic                  present,
	input  logic                  last_candidate,
	// controller
	input  ctrl_cmd_t             cmd,
	output dp_stat_t              stat,
	// result
	output logic [DISP_OUT_W-1:0] disparity_q4,
	output logic                  found
);

	localparam int CW   = $clog2(MAX_CANDIDATES);
	localparam int BW   = ((CW + 1 > MIN_DISP_W) ? CW + 1 : MIN_DISP_W) + 1;
	localparam int FW   = (BW + FRAC_BITS + 1 > DISP_OUT_W) ? BW + FRAC_BITS + 1 : DISP_OUT_W;
	localparam int QW   = FRAC_BITS + 2;
	localparam int DSW  = 20 + FRAC_BITS;
	localparam int NW   = 18 + FRAC_BITS;
	localparam int TW   = COST_W + 1;   // cost plus usable flag
	localparam logic [CW-1:0] LAST_IDX = CW'(MAX_CANDIDATES - 1);
	localparam logic [QW-1:0] LIM  = {{(QW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
	localparam logic [FW-1:0] UNIT = {{(FW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [FW-1:0] UNIT_NEG = ~UNIT + {{(FW-1){1'b0}}, 1'b1};

	// configuration registers
	logic [MIN_DISP_W-1:0] min_disp_q;
	logic                  subpix_en_q;
	logic [COST_W-1:0]     invalid_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_disp_q     <= '0;
			subpix_en_q    <= 1'b1;
			invalid_cost_q <= '1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIN_DISP:     min_disp_q     <= cfg_data[MIN_DISP_W-1:0];
				REG_SUBPIX_EN:    subpix_en_q    <= cfg_data[0];
				REG_INVALID_COST: invalid_cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-pixel search state
	logic [CW-1:0]     cnt_q;
	logic [COST_W-1:0] best_cost_q;
	logic [CW-1:0]     best_idx_q;
	logic              have_best_q;
	logic [TW-1:0]     prev_q, before_q, after_q;
	logic              awaiting_q;

	logic              last_eff, usable, take, in_xfer;
	logic [TW-1:0]     cand_tag;
	logic [COST_W-1:0] nxt_best_cost;
	logic [CW-1:0]     nxt_best_idx;
	logic              nxt_have;
	logic [TW-1:0]     nxt_before, nxt_after;
	logic              nxt_awaiting;

	assign last_eff = last_candidate || (cnt_q == LAST_IDX);
	assign in_stall = cmd.busy && last_eff;
	assign in_xfer  = in_valid && !in_stall;
	assign usable   = present && (cost != invalid_cost_q);
	assign cand_tag = usable ? {1'b1, cost} : '0;
	assign take     = usable && (!have_best_q || cost < best_cost_q);

	always_comb begin
		nxt_best_cost = best_cost_q;
		nxt_best_idx  = best_idx_q;
		nxt_have      = have_best_q;
		nxt_before    = before_q;
		nxt_after     = after_q;
		nxt_awaiting  = awaiting_q;
		if (take) begin
			nxt_best_cost = cost;
			nxt_best_idx  = cnt_q;
			nxt_have      = 1'b1;
			nxt_before    = prev_q;
			nxt_after     = '0;
			nxt_awaiting  = 1'b1;
		end else if (awaiting_q) begin
			nxt_after    = cand_tag;
			nxt_awaiting = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			best_cost_q <= '1;
			best_idx_q  <= '0;
			have_best_q <= 1'b0;
			prev_q      <= '0;
			before_q    <= '0;
			after_q     <= '0;
			awaiting_q  <= 1'b0;
		end else if (in_xfer) begin
			if (last_eff) begin
				cnt_q       <= '0;
				best_cost_q <= '1;
				best_idx_q  <= '0;
				have_best_q <= 1'b0;
				prev_q      <= '0;
				before_q    <= '0;
				after_q     <= '0;
				awaiting_q  <= 1'b0;
			end else begin
				cnt_q       <= cnt_q + 1'b1;
				best_cost_q <= nxt_best_cost;
				best_idx_q  <= nxt_best_idx;
				have_best_q <= nxt_have;
				prev_q      <= cand_tag;
				before_q    <= nxt_before;
				after_q     <= nxt_after;
				awaiting_q  <= nxt_awaiting;
			end
		end
	end

	// snapshot of the finished pixel; registers sampled at its last transfer
	logic              fin_found_q, fin_sub_q;
	logic [BW-1:0]     fin_base_q;
	logic [COST_W-1:0] fin_cm_q, fin_c0_q, fin_cp_q;

	always_ff @(posedge clk) begin
		if (in_xfer && last_eff) begin
			fin_found_q <= nxt_have;
			fin_sub_q   <= nxt_have && subpix_en_q && nxt_before[COST_W] && nxt_after[COST_W];
			fin_base_q  <= {{(BW-MIN_DISP_W){min_disp_q[MIN_DISP_W-1]}}, min_disp_q}
			             + {{(BW-CW){1'b0}}, nxt_best_idx};
			fin_cm_q    <= nxt_before[COST_W-1:0];
			fin_c0_q    <= nxt_best_cost;
			fin_cp_q    <= nxt_after[COST_W-1:0];
		end
	end

	// parabola offset: q = (|cm-cp|*2^F + |den|) / (2|den|), den = cm - 2c0 + cp
	logic [18:0]      den_q;
	logic [COST_W:0]  diff_q;
	logic [DSW-1:0]   rem_q, dsh_q;
	logic [QW-1:0]    q_q;
	logic             neg_q;
	logic [18:0]      den_abs_w;
	logic [COST_W:0]  diff_abs_w;
	logic [NW-1:0]    dividend;
	logic [17:0]      den_abs;
	logic [DSW-1:0]   rem_sub;
	logic             fits;

	assign den_abs_w  = den_q[18] ? (19'd0 - den_q) : den_q;
	assign diff_abs_w = diff_q[COST_W] ? ({(COST_W+1){1'b0}} - diff_q) : diff_q;
	assign den_abs    = den_abs_w[17:0];
	assign dividend   = {{(NW-COST_W-FRAC_BITS){1'b0}}, diff_abs_w[COST_W-1:0],
	                     {FRAC_BITS{1'b0}}} + {{(NW-18){1'b0}}, den_abs};
	assign rem_sub    = rem_q - dsh_q;
	assign fits       = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		if (cmd.prep1) begin
			den_q  <= {3'b000, fin_cm_q} - {2'b00, fin_c0_q, 1'b0} + {3'b000, fin_cp_q};
			diff_q <= {1'b0, fin_cm_q} - {1'b0, fin_cp_q};
		end
		if (cmd.prep2) begin
			rem_q <= {{(DSW-NW){1'b0}}, dividend};
			// divisor 2|den| aligned to the top quotient bit
			dsh_q <= {den_abs, {(FRAC_BITS+2){1'b0}}};
			q_q   <= '0;
			neg_q <= diff_q[COST_W] ^ den_q[18];
		end else if (cmd.step) begin
			if (fits)
				rem_q <= rem_sub;
			dsh_q <= dsh_q >> 1;
			q_q   <= {q_q[QW-2:0], fits};
		end
	end

	assign stat.fin_start = in_xfer && last_eff;
	assign stat.use_div   = fin_sub_q && (den_q != '0);

	// result register
	logic [QW-1:0]         q_clamped;
	logic [FW-1:0]         base_ext, offset, disp_full;
	logic [DISP_OUT_W-1:0] disp_q;
	logic                  found_q;

	assign q_clamped = (q_q > LIM) ? LIM : q_q;
	assign base_ext  = {{(FW-BW){fin_base_q[BW-1]}}, fin_base_q} << FRAC_BITS;
	assign offset    = neg_q ? ({FW{1'b0}} - {{(FW-QW){1'b0}}, q_clamped})
	                         : {{(FW-QW){1'b0}}, q_clamped};
	assign disp_full = fin_found_q ? (base_ext + offset) : UNIT_NEG;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			disp_q  <= disp_full[DISP_OUT_W-1:0];
			found_q <= fin_found_q;
		end
	end

	assign disparity_q4 = disp_q;
	assign found        = found_q;

endmodule

@@ hdl/right_disparity_wta_subpixel_core.sv @@
// ----------------------------------------------------------------------------
// right_disparity_wta_subpixel_core - winner-take-all disparity with
// parabola subpixel refinement for one right-image pixel at a time
//
// Candidates come in on the in_valid/in_stall channel, one cost per transfer,
// in increasing disparity order; last_candidate (or the candidate at index
// MAX_CANDIDATES-1) closes the pixel. Exactly one result per pixel leaves on
// the out_valid/out_stall channel.
// Throughput: one candidate per cycle while in_stall is low. A closed pixel
// is finished by a separate sequencer while the next pixel's candidates keep
// streaming in. After the last candidate's transfer the sequencer steps
// through PREP1, PREP2, the divider (only when an offset is computed; one
// quotient bit per cycle, FRAC_BITS + 2 bits), FIX and OUT. The result stays
// in the output register until taken; while it is pending or being finished,
// only a last candidate is stalled, so short pixels see stalls.
// Reset clears the search state and loads the register defaults
// (base disparity 0, subpixel_enable 1, invalid_cost_code 0xFFFF).
// Configuration writes take effect at once; write only when idle.
// ----------------------------------------------------------------------------
module right_disparity_wta_subpixel_core import rdwta_pkg::*; #(
	parameter int MAX_CANDIDATES = 256,
	parameter int FRAC_BITS      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COST_W-1:0]     cost,
	input  logic                  present,
	input  logic                  last_candidate,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DISP_OUT_W-1:0] disparity_q4,
	output logic                  found
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rdwta_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.out_stall (out_stall),
		.cmd       (cmd),
		.out_valid (out_valid)
	);

	rdwta_dp #(
		.MAX_CANDIDATES (MAX_CANDIDATES),
		.FRAC_BITS      (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cost           (cost),
		.present        (present),
		.last_candidate (last_candidate),
		.cmd            (cmd),
		.stat           (stat),
		.disparity_q4   (disparity_q4),
		.found          (found)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - testbench for right_disparity_wta_subpixel_core
// Streams disparity candidates into the core and predicts each pixel's
// winner-take-all disparity with parabola refinement in a local model. Every
// result transfer is checked field by field against the oldest prediction.
// The run steps through several register settings and idle / stall profiles.
// ----------------------------------------------------------------------------
module tb_top import rdwta_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CANDS      = 256;
	localparam int FRAC_BITS      = 4;
	localparam int HALF_STEP      = 1 << (FRAC_BITS - 1);
	localparam int SETTLE_CYCLES  = 2 * (FRAC_BITS + 5);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 30;

	// index past the end of the register file, writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              present;
		logic              closes;
	} cand_t;

	typedef struct packed {
		logic [DISP_OUT_W-1:0] disparity;
		logic                  found;
	} pix_result_t;

	typedef enum {PIX_BOWL, PIX_NOISE, PIX_SPARSE, PIX_EXTREME} pix_kind_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_write      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [COST_W-1:0]     cost           = '0;
	logic                  present        = 1'b0;
	logic                  last_candidate = 1'b0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic [DISP_OUT_W-1:0] disparity_q4;
	logic                  found;

	right_disparity_wta_subpixel_core #(
		.MAX_CANDIDATES(MAX_CANDS),
		.FRAC_BITS     (FRAC_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cost          (cost),
		.present       (present),
		.last_candidate(last_candidate),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.disparity_q4  (disparity_q4),
		.found         (found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cand_t       pending_cands[$];
	pix_result_t expected_results[$];
	cand_t       drv_cand;
	pix_result_t mon_want;
	int          send_idle_pct = 0;
	int          rcv_stall_pct = 0;
	int          error_count   = 0;
	int          quiet_cycles  = 0;

	// register copies
	int                min_disp_q     = 0;
	logic              subpix_q       = 1'b1;
	logic [COST_W-1:0] invalid_code_q = 16'hFFFF;

	// search state of the pixel in flight
	logic [7:0]        pix_idx    = '0;
	logic [COST_W-1:0] win_cost   = 16'hFFFF;
	logic [7:0]        win_idx    = '0;
	logic              win_valid  = 1'b0;
	logic [COST_W:0]   prev_tag   = '0;
	logic [COST_W:0]   left_tag   = '0;
	logic [COST_W:0]   right_tag  = '0;
	logic              want_right = 1'b0;

	function automatic int parabola_q(int cm, int c0, int cp);
		longint den2;
		longint num;
		longint an;
		longint ad;
		longint q;
		den2 = 2 * longint'(cm - 2 * c0 + cp);
		if (den2 == 0)
			return 0;
		num = longint'(cm - cp) * (1 << FRAC_BITS);
		an = (num < 0) ? -num : num;
		ad = (den2 < 0) ? -den2 : den2;
		q = (an + ad / 2) / ad;
		if (q > HALF_STEP)
			q = HALF_STEP;
		return ((num < 0) != (den2 < 0)) ? -int'(q) : int'(q);
	endfunction

	function automatic void take_candidate(logic [COST_W-1:0] c, logic pres, logic lst);
		logic            usable;
		logic [COST_W:0] tag;
		logic            closes;
		int              disp;
		pix_result_t     res;
		usable = pres && (c != invalid_code_q);
		tag = usable ? {1'b1, c} : '0;
		closes = lst || (pix_idx == 8'(MAX_CANDS - 1));
		if (usable && (!win_valid || c < win_cost)) begin
			win_valid = 1'b1;
			win_cost = c;
			win_idx = pix_idx;
			left_tag = prev_tag;
			right_tag = '0;
			want_right = 1'b1;
		end else if (want_right) begin
			right_tag = tag;
			want_right = 1'b0;
		end
		prev_tag = tag;
		if (!closes) begin
			pix_idx = pix_idx + 8'd1;
			return;
		end
		if (win_valid) begin
			disp = (min_disp_q + int'(win_idx)) * (1 << FRAC_BITS);
			if (subpix_q && left_tag[COST_W] && right_tag[COST_W])
				disp += parabola_q(int'(left_tag[COST_W-1:0]), int'(win_cost),
					int'(right_tag[COST_W-1:0]));
			res.disparity = DISP_OUT_W'(disp);
			res.found = 1'b1;
		end else begin
			res.disparity = DISP_OUT_W'(-(1 << FRAC_BITS));
			res.found = 1'b0;
		end
		expected_results.push_back(res);
		pix_idx = '0;
		win_cost = 16'hFFFF;
		win_idx = '0;
		win_valid = 1'b0;
		prev_tag = '0;
		left_tag = '0;
		right_tag = '0;
		want_right = 1'b0;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// sender
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			take_candidate(cost, present, last_candidate);
		if (!in_valid || !in_stall) begin
			if (pending_cands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_cand = pending_cands.pop_front();
				in_valid <= 1'b1;
				cost <= drv_cand.cost;
				present <= drv_cand.present;
				last_candidate <= drv_cand.closes;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending, disparity",
						int'($signed(disparity_q4)), 0);
				end else begin
					mon_want = expected_results.pop_front();
					if (disparity_q4 !== mon_want.disparity)
						report_mismatch("disparity_q4", int'($signed(disparity_q4)),
							int'($signed(mon_want.disparity)));
					if (found !== mon_want.found)
						report_mismatch("found", int'(found), int'(mon_want.found));
				end
			end
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_MIN_DISP:     min_disp_q = int'($signed(data[MIN_DISP_W-1:0]));
			REG_SUBPIX_EN:    subpix_q = data[0];
			REG_INVALID_COST: invalid_code_q = data[COST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_cand(logic [COST_W-1:0] c, logic pres, logic lst);
		cand_t item;
		item.cost = c;
		item.present = pres;
		item.closes = lst;
		pending_cands.push_back(item);
	endtask

	// open_end leaves last_candidate low so the index limit closes the pixel
	task automatic add_pixel(int n, pix_kind_t kind, bit open_end);
		int                ctr;
		int                slope;
		int                base;
		longint            v;
		logic [COST_W-1:0] c;
		logic              p;
		ctr = open_end ? $urandom_range(n - 12, n - 3) : $urandom_range(0, n - 1);
		slope = $urandom_range(1, 3000);
		base = $urandom_range(0, 30000);
		for (int i = 0; i < n; i++) begin
			case (kind)
				PIX_BOWL: begin
					v = base + longint'(slope) * (i - ctr) * (i - ctr) + $urandom_range(0, slope);
					c = (v > 65535) ? 16'hFFFF : COST_W'(v);
					p = ($urandom_range(0, 15) != 0);
				end
				PIX_NOISE: begin
					c = COST_W'($urandom_range(0, 65535));
					p = $urandom_range(0, 1);
				end
				PIX_SPARSE: begin
					c = $urandom_range(0, 1) ? invalid_code_q : COST_W'($urandom_range(0, 65535));
					p = ($urandom_range(0, 3) == 0);
				end
				default: begin
					case ($urandom_range(0, 4))
						0: c = '0;
						1: c = 16'hFFFF;
						2: c = invalid_code_q;
						3: c = 16'hFFFE;
						default: c = COST_W'($urandom);
					endcase
					p = ($urandom_range(0, 3) != 0);
				end
			endcase
			push_cand(c, p, !open_end && (i == n - 1));
		end
	endtask

	task automatic queue_pixels(int target);
		int        added;
		int        n;
		int        r;
		pix_kind_t kind;
		added = 0;
		while (added < target) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				n = $urandom_range(1, 8);
			else if (r < 9)
				n = $urandom_range(9, 24);
			else
				n = $urandom_range(25, 60);
			r = $urandom_range(0, 9);
			if (r < 6)
				kind = PIX_BOWL;
			else if (r < 8)
				kind = PIX_NOISE;
			else if (r < 9)
				kind = PIX_SPARSE;
			else
				kind = PIX_EXTREME;
			add_pixel(n, kind, 1'b0);
			added += n;
		end
	endtask

	task automatic wait_drained();
		while (pending_cands.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_idle(int snd, int rcv);
		@(negedge clk);
		send_idle_pct = snd;
		rcv_stall_pct = rcv;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed pixels at the reset register values
		set_idle(0, 0);
		push_cand(16'd0, 1'b1, 1'b1);
		push_cand(16'd123, 1'b0, 1'b1);
		push_cand(16'd100, 1'b1, 1'b0);
		push_cand(16'd40, 1'b1, 1'b0);
		push_cand(16'd70, 1'b1, 1'b1);
		push_cand(16'd10, 1'b1, 1'b0);
		push_cand(16'd20, 1'b1, 1'b0);
		push_cand(16'd30, 1'b1, 1'b1);
		push_cand(16'd30, 1'b1, 1'b0);
		push_cand(16'd20, 1'b1, 1'b0);
		push_cand(16'd10, 1'b1, 1'b1);
		push_cand(16'hFFFF, 1'b1, 1'b0);
		push_cand(16'd5, 1'b0, 1'b1);
		push_cand(16'd50, 1'b1, 1'b0);
		push_cand(16'd50, 1'b1, 1'b0);
		push_cand(16'd50, 1'b1, 1'b1);
		// a later winner drops the after-neighbour of the earlier one
		push_cand(16'd80, 1'b1, 1'b0);
		push_cand(16'd60, 1'b1, 1'b0);
		push_cand(16'd70, 1'b1, 1'b0);
		push_cand(16'd40, 1'b1, 1'b0);
		push_cand(16'hFFFF, 1'b1, 1'b1);
		// offset lands exactly on the half-step clamp
		push_cand(16'd60000, 1'b1, 1'b0);
		push_cand(16'd0, 1'b1, 1'b0);
		push_cand(16'd0, 1'b1, 1'b1);
		wait_drained();

		// base disparity -128, zero cost marks unusable
		write_reg(REG_MIN_DISP, CFG_DATA_W'(-128));
		write_reg(REG_INVALID_COST, 16'h0000);
		set_idle(0, 0);
		push_cand(16'hFFFF, 1'b1, 1'b0);
		push_cand(16'hFFFF, 1'b1, 1'b1);
		push_cand(16'd0, 1'b1, 1'b1);
		queue_pixels(RANDOM_ITEMS);
		wait_drained();

		write_reg(REG_MIN_DISP, CFG_DATA_W'(255));
		write_reg(REG_SUBPIX_EN, 16'h0000);
		write_reg(REG_INVALID_COST, 16'hFFFF);
		set_idle(49, 0);
		queue_pixels(RANDOM_ITEMS);
		wait_drained();

		// junk above the register widths must be dropped
		write_reg(REG_MIN_DISP, {7'($urandom), 9'($urandom_range(0, 383) - 128)});
		write_reg(REG_SUBPIX_EN, {15'($urandom), 1'b1});
		write_reg(REG_INVALID_COST, 16'($urandom));
		write_reg(REG_UNUSED, 16'($urandom));
		set_idle(0, 49);
		queue_pixels(RANDOM_ITEMS);
		wait_drained();

		write_reg(REG_MIN_DISP, CFG_DATA_W'(255));
		write_reg(REG_INVALID_COST, 16'h8000);
		set_idle(19, 19);
		queue_pixels(RANDOM_ITEMS / 2);
		// hold the sender until the core has delivered everything
		wait_drained();
		add_pixel(MAX_CANDS, PIX_BOWL, 1'b1);
		queue_pixels(RANDOM_ITEMS / 2);
		wait_drained();

		write_reg(REG_MIN_DISP, CFG_DATA_W'(-128));
		write_reg(REG_INVALID_COST, 16'hFFFF);
		set_idle(19, 19);
		queue_pixels(RANDOM_ITEMS);
		wait_drained();

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
